FILE: sv/lpc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lpc_pkg
// shared constants and types for the recent lba proximity counter
// ---------------------------------------------------------------------------
package lpc_pkg;

  localparam int DIST_W    = 48;
  localparam int TOTAL_W   = 48;
  localparam int RC_W      = 5;
  localparam int CFG_W     = 49;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RECENT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_BLOCKS  = 2'd2;

  localparam logic [RC_W-1:0]  RECENT_COUNT_RST = 5'd16;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST  = 49'd0;
  localparam logic [CFG_W-1:0] DISK_BLOCKS_RST  = 49'h1_0000_0000_0000;

  typedef struct packed {
    logic              vld;
    logic              busy;
    logic [DIST_W-1:0] span;
  } dist_res_t;

endpackage
`default_nettype wire

FILE: sv/lpc_ring_mem.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lpc_ring_mem
// ring of recent addresses, one write and one registered read port
// ---------------------------------------------------------------------------
module lpc_ring_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/lpc_dist_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lpc_dist_unit
// shared two-stage absolute difference and clamp unit
// ---------------------------------------------------------------------------
module lpc_dist_unit #(
  parameter int LBA_BITS = 48
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_vld,
  input  wire logic [LBA_BITS-1:0]       lba,
  input  wire logic [LBA_BITS-1:0]       entry,
  input  wire logic [lpc_pkg::DIST_W-1:0] lim,
  output lpc_pkg::dist_res_t             res
);
  import lpc_pkg::*;

  localparam int CMP_W = (LBA_BITS > DIST_W) ? LBA_BITS : DIST_W;

  logic [LBA_BITS:0]   diff_ab;
  logic [LBA_BITS:0]   diff_ba;
  logic [LBA_BITS-1:0] abs_nxt;
  logic [LBA_BITS-1:0] abs_r;
  logic                v1_r;
  logic                v2_r;
  logic [DIST_W-1:0]   clamp_nxt;
  logic [DIST_W-1:0]   clamp_r;
  logic [CMP_W-1:0]    abs_ext;
  logic [CMP_W-1:0]    lim_ext;

  assign diff_ab = {1'b0, lba} - {1'b0, entry};
  assign diff_ba = {1'b0, entry} - {1'b0, lba};
  assign abs_nxt = diff_ab[LBA_BITS] ? diff_ba[LBA_BITS-1:0] : diff_ab[LBA_BITS-1:0];

  assign abs_ext   = CMP_W'(abs_r);
  assign lim_ext   = CMP_W'(lim);
  assign clamp_nxt = (abs_ext >= lim_ext) ? lim : abs_ext[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    abs_r   <= abs_nxt;
    clamp_r <= clamp_nxt;
  end

  assign res.vld  = v2_r;
  assign res.busy = v1_r;
  assign res.span = clamp_r;

endmodule
`default_nettype wire

FILE: sv/recent_lba_proximity_counter_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// recent lba proximity counter
// one transaction at a time: in_stall stays high until the result is loaded
// into the output register; while the ring fills an address is only stored,
// once scoring, one ring entry per cycle goes through the distance unit
// reset clears totals, fill level and replace slot and restores config defaults; ring contents undefined
// ---------------------------------------------------------------------------
module recent_lba_proximity_counter_unit #(
  parameter int RING_DEPTH = 16,
  parameter int LBA_BITS   = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [LBA_BITS-1:0]           in_request_lba,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_scored,
  output logic                               out_is_near,
  output logic [lpc_pkg::DIST_W-1:0]         out_min_distance,
  output logic [lpc_pkg::TOTAL_W-1:0]        out_near_total,
  output logic [lpc_pkg::TOTAL_W-1:0]        out_scored_total,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lpc_pkg::CFG_W-1:0]     cfg_data
);
  import lpc_pkg::*;

  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W = $clog2(RING_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [RC_W-1:0]     recent_count_r;
  logic [CFG_W-1:0]    window_r;
  logic [CFG_W-1:0]    disk_r;
  logic [FILL_W-1:0]   fill_r;
  logic [IDX_W-1:0]    oldest_r;
  logic [TOTAL_W-1:0]  near_total_r, near_total_nxt;
  logic [TOTAL_W-1:0]  scored_total_r, scored_total_nxt;
  logic [LBA_BITS-1:0] lba_r;
  logic                scored_r;
  logic [CFG_W-1:0]    min_r;
  logic [FILL_W-1:0]   rd_cnt_r;
  logic                rd_vld_r;
  logic                out_valid_r;
  logic                out_scored_r;
  logic                out_is_near_r;
  logic [DIST_W-1:0]   out_min_r;
  logic [TOTAL_W-1:0]  out_near_r;
  logic [TOTAL_W-1:0]  out_scored_tot_r;

  logic [FILL_W-1:0]   count;
  logic                in_acc;
  logic                issue;
  logic                scan_done;
  logic                out_free;
  logic                finish;
  logic                near;
  logic [IDX_W-1:0]    slot;
  logic [FILL_W-1:0]   slot_inc;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [LBA_BITS-1:0] rd_data;
  dist_res_t           dres;

  // effective compare count
  always_comb begin
    if (recent_count_r == '0) begin
      count = FILL_W'(1);
    end else if (32'(recent_count_r) > RING_DEPTH) begin
      count = FILL_W'(RING_DEPTH);
    end else begin
      count = FILL_W'(recent_count_r);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign issue     = (state_r == ST_SCAN) && (rd_cnt_r < fill_r);
  assign scan_done = (state_r == ST_SCAN) && (rd_cnt_r == fill_r) && !rd_vld_r && !dres.busy;
  assign out_free  = !out_valid_r || !out_stall;
  assign finish    = (state_r == ST_FINISH) && out_free;
  assign near      = scored_r && (min_r < window_r);

  assign slot     = (FILL_W'(oldest_r) < count) ? oldest_r : '0;
  assign slot_inc = FILL_W'(slot) + FILL_W'(1);
  assign wr_en    = finish;
  assign wr_addr  = scored_r ? slot : fill_r[IDX_W-1:0];

  assign near_total_nxt   = (near && (near_total_r != '1)) ? near_total_r + 1'b1 : near_total_r;
  assign scored_total_nxt = (scored_r && (scored_total_r != '1)) ?
                            scored_total_r + 1'b1 : scored_total_r;

  lpc_ring_mem #(
    .DEPTH (RING_DEPTH),
    .WIDTH (LBA_BITS),
    .AW    (IDX_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (lba_r),
    .rd_en   (issue),
    .rd_addr (rd_cnt_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  lpc_dist_unit #(
    .LBA_BITS (LBA_BITS)
  ) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (rd_vld_r),
    .lba    (lba_r),
    .entry  (rd_data),
    .lim    (disk_r[CFG_W-1:1]),
    .res    (dres)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (fill_r < count) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      recent_count_r <= RECENT_COUNT_RST;
      window_r       <= WINDOW_SIZE_RST;
      disk_r         <= DISK_BLOCKS_RST;
      fill_r         <= '0;
      oldest_r       <= '0;
      near_total_r   <= '0;
      scored_total_r <= '0;
      rd_cnt_r       <= '0;
      rd_vld_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RECENT_COUNT: recent_count_r <= cfg_data[RC_W-1:0];
          CFG_WINDOW_SIZE:  window_r       <= cfg_data;
          CFG_DISK_BLOCKS:  disk_r         <= cfg_data;
          default:          ;
        endcase
      end
      if (in_acc) begin
        rd_cnt_r <= '0;
      end else if (issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      if (finish) begin
        if (scored_r) begin
          oldest_r <= (slot_inc == count) ? '0 : slot_inc[IDX_W-1:0];
        end else begin
          fill_r   <= fill_r + 1'b1;
          oldest_r <= '0;
        end
        near_total_r   <= near_total_nxt;
        scored_total_r <= scored_total_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload and running minimum
  always_ff @(posedge clk) begin
    if (in_acc) begin
      lba_r    <= in_request_lba;
      scored_r <= !(fill_r < count);
      min_r    <= disk_r;
    end else if (dres.vld && ({1'b0, dres.span} < min_r)) begin
      min_r <= {1'b0, dres.span};
    end
    if (finish) begin
      out_scored_r     <= scored_r;
      out_is_near_r    <= near;
      out_min_r        <= scored_r ? min_r[DIST_W-1:0] : '0;
      out_near_r       <= near_total_nxt;
      out_scored_tot_r <= scored_total_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scored       = out_scored_r;
  assign out_is_near      = out_is_near_r;
  assign out_min_distance = out_min_r;
  assign out_near_total   = out_near_r;
  assign out_scored_total = out_scored_tot_r;

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN || state_r == ST_FINISH))
    else $error("accepted transaction did not start work");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (rd_cnt_r < fill_r && fill_r <= FILL_W'(RING_DEPTH)))
    else $error("ring read beyond fill level");

  a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (out_valid && state_r == ST_IDLE))
    else $error("result not loaded on finish");

  a_near_needs_score: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_near) |-> out_scored)
    else $error("near flag on unscored transaction");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/lba_proximity_checker.sv
// ---------------------------------------------------------------------------
// lba proximity checker
// watches the request, result and register channels of the proximity
// counter, keeps its own ring of recent addresses and running totals, and
// compares every result transaction field by field with the oldest score
// worked out for an accepted request
// ---------------------------------------------------------------------------
module lba_proximity_checker #(
  parameter int RING_DEPTH = 16,
  parameter int LBA_BITS   = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [LBA_BITS-1:0]           in_request_lba,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_scored,
  input  logic                          out_is_near,
  input  logic [lpc_pkg::DIST_W-1:0]    out_min_distance,
  input  logic [lpc_pkg::TOTAL_W-1:0]   out_near_total,
  input  logic [lpc_pkg::TOTAL_W-1:0]   out_scored_total,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpc_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatch_count,
  output int                            outstanding
);
  import lpc_pkg::*;

  typedef struct packed {
    logic               scored;
    logic               is_near;
    logic [DIST_W-1:0]  min_distance;
    logic [TOTAL_W-1:0] near_total;
    logic [TOTAL_W-1:0] scored_total;
  } proximity_score_t;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  logic [LBA_BITS-1:0] ring_lba [RING_DEPTH];
  int unsigned         ring_fill;
  int unsigned         replace_slot;
  logic [TOTAL_W-1:0]  near_cnt;
  logic [TOTAL_W-1:0]  scored_cnt;
  logic [RC_W-1:0]     recent_count_q;
  logic [CFG_W-1:0]    window_q;
  logic [CFG_W-1:0]    disk_q;
  proximity_score_t    expected_scores [$];

  function automatic int unsigned compared_count();
    if (recent_count_q == '0) return 1;
    if (recent_count_q > RING_DEPTH) return RING_DEPTH;
    return recent_count_q;
  endfunction

  function automatic proximity_score_t score_request(input logic [LBA_BITS-1:0] lba);
    proximity_score_t res;
    int unsigned      cnt;
    int unsigned      slot;
    int unsigned      k;
    logic [CFG_W-1:0] best;
    logic [CFG_W-1:0] gap;
    logic [CFG_W-1:0] clamp;
    cnt = compared_count();
    res = '0;
    if (ring_fill < cnt) begin
      // still filling, store only
      if (ring_fill < RING_DEPTH) begin
        ring_lba[ring_fill] = lba;
        ring_fill++;
      end
      replace_slot = 0;
    end else begin
      clamp = disk_q >> 1;
      best  = disk_q;
      for (k = 0; k < ring_fill && k < RING_DEPTH; k++) begin
        gap = (lba > ring_lba[k]) ? CFG_W'(lba - ring_lba[k]) : CFG_W'(ring_lba[k] - lba);
        if (gap > clamp) gap = clamp;
        if (gap < best) best = gap;
      end
      res.scored       = 1'b1;
      res.min_distance = best[DIST_W-1:0];
      if (best < window_q) begin
        res.is_near = 1'b1;
        if (near_cnt != TOTAL_MAX) near_cnt++;
      end
      if (scored_cnt != TOTAL_MAX) scored_cnt++;
      slot = (replace_slot < cnt) ? replace_slot : 0;
      ring_lba[slot] = lba;
      replace_slot = (slot + 1) % cnt;
    end
    res.near_total   = near_cnt;
    res.scored_total = scored_cnt;
    return res;
  endfunction

  task automatic queue_score(input proximity_score_t score);
    expected_scores = {expected_scores, score};
  endtask

  task automatic check_field(input string name, input logic [DIST_W-1:0] want,
                             input logic [DIST_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    proximity_score_t want;
    if (!rst_n) begin
      ring_fill      = 0;
      replace_slot   = 0;
      near_cnt       = '0;
      scored_cnt     = '0;
      recent_count_q = RECENT_COUNT_RST;
      window_q       = WINDOW_SIZE_RST;
      disk_q         = DISK_BLOCKS_RST;
      expected_scores.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_scores.size() == 0) begin
          $error("result transaction with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_scores.pop_front();
          check_field("scored", DIST_W'(want.scored), DIST_W'(out_scored));
          check_field("is_near", DIST_W'(want.is_near), DIST_W'(out_is_near));
          check_field("min_distance", want.min_distance, out_min_distance);
          check_field("near_total", want.near_total, out_near_total);
          check_field("scored_total", want.scored_total, out_scored_total);
        end
      end
      if (in_valid && !in_stall) queue_score(score_request(in_request_lba));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RECENT_COUNT: recent_count_q = cfg_data[RC_W-1:0];
          CFG_WINDOW_SIZE:  window_q = cfg_data;
          CFG_DISK_BLOCKS:  disk_q = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= expected_scores.size();
  end

endmodule

FILE: tb/sv/tb_recent_lba_proximity_counter_unit.sv
// ---------------------------------------------------------------------------
// recent lba proximity counter testbench
// drives request addresses through several register settings, from a short
// directed fill and score sequence to long random runs of nearby and far
// addresses, with sender gaps, receiver stalls and one long receiver
// hold-off; a checker beside the block predicts and compares each result
// ---------------------------------------------------------------------------
module tb_recent_lba_proximity_counter_unit;
  import lpc_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int LBA_BITS    = 48;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_OFF    = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [LBA_BITS-1:0]  in_request_lba;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_scored;
  logic                 out_is_near;
  logic [DIST_W-1:0]    out_min_distance;
  logic [TOTAL_W-1:0]   out_near_total;
  logic [TOTAL_W-1:0]   out_scored_total;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatch_count;
  int                   outstanding;

  int                   send_idle_pct = 0;
  int                   stall_pct = 0;
  int                   hold_cycles = 0;
  int                   quiet_cycles = 0;
  logic [LBA_BITS-1:0]  last_lba = '0;

  recent_lba_proximity_counter_unit #(
    .RING_DEPTH(RING_DEPTH),
    .LBA_BITS  (LBA_BITS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_request_lba  (in_request_lba),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_scored      (out_scored),
    .out_is_near     (out_is_near),
    .out_min_distance(out_min_distance),
    .out_near_total  (out_near_total),
    .out_scored_total(out_scored_total),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  lba_proximity_checker #(
    .RING_DEPTH(RING_DEPTH),
    .LBA_BITS  (LBA_BITS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_request_lba  (in_request_lba),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_scored      (out_scored),
    .out_is_near     (out_is_near),
    .out_min_distance(out_min_distance),
    .out_near_total  (out_near_total),
    .out_scored_total(out_scored_total),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver side, random stalls or a counted hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        hold_left = hold_cycles;
        hold_cycles = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [RC_W-1:0] rc, input logic [CFG_W-1:0] ws,
                           input logic [CFG_W-1:0] db);
    write_reg(CFG_RECENT_COUNT, CFG_W'(rc));
    write_reg(CFG_WINDOW_SIZE, ws);
    write_reg(CFG_DISK_BLOCKS, db);
    cfg_valid <= 1'b0;
  endtask

  // sender idles cycle by cycle before offering the next transaction
  task automatic send_request(input logic [LBA_BITS-1:0] lba);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_request_lba <= lba;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_lba = lba;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // mostly addresses close to the last one, some far, some at the extremes
  function automatic logic [LBA_BITS-1:0] pick_lba(input logic [CFG_W-1:0] window);
    logic [LBA_BITS-1:0] step;
    case ($urandom_range(0, 9))
      0, 1: return LBA_BITS'({$urandom, $urandom});
      2: return $urandom_range(0, 1) ? '0 : '1;
      3: return last_lba + LBA_BITS'(window) - LBA_BITS'($urandom_range(0, 1));
      default: begin
        step = LBA_BITS'($urandom) >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? last_lba + step : last_lba - step;
      end
    endcase
  endfunction

  task automatic run_phase(input logic [RC_W-1:0] rc, input logic [CFG_W-1:0] ws,
                           input logic [CFG_W-1:0] db, input int n, input int mode,
                           input bit squeeze);
    configure(rc, ws, db);
    case (mode)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 45; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 45; end
      default: begin send_idle_pct = 29; stall_pct = 29; end
    endcase
    if (squeeze) hold_cycles = HOLD_OFF;
    repeat (n) send_request(pick_lba(ws));
    wait_drained();
  endtask

  initial begin
    logic [CFG_W-1:0] rand_window;
    logic [CFG_W-1:0] rand_disk;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_request_lba <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_RECENT_COUNT;
    cfg_data       <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // short ring: fill, then window boundary and extremes
    configure(5'd3, 49'd16, DISK_BLOCKS_RST);
    send_request('0);
    send_request('1);
    send_request(48'hAAAA_AAAA_AAAA);
    send_request(48'd5);
    send_request(48'hFFFF_FFFF_FFFC);
    send_request(48'h5555_5555_5555);
    send_request(48'd16);
    send_request(48'd15);
    send_request('0);
    wait_drained();

    run_phase(5'd8, 49'd1000, 49'd8192, 100, 0, 1'b0);
    run_phase(5'd0, '1, 49'd0, 60, 1, 1'b0);
    run_phase(5'd31, 49'd0, '1, 150, 2, 1'b1);
    run_phase(5'd5, 49'h10_0000, 49'd1, 120, 3, 1'b0);
    rand_window = CFG_W'({$urandom, $urandom}) >> $urandom_range(0, 40);
    rand_disk   = CFG_W'({$urandom, $urandom}) >> $urandom_range(0, 40);
    run_phase(5'd16, rand_window, rand_disk, 150, 0, 1'b0);
    run_phase(5'd2, 49'd65536, DISK_BLOCKS_RST, 150, 1, 1'b0);
    run_phase(5'd12, 49'd4096, 49'h10_0000, 150, 2, 1'b0);
    run_phase(5'd1, 49'd1, 49'd3, 100, 3, 1'b0);
    run_phase(5'd16, 49'h1_0000_0000_0000, DISK_BLOCKS_RST, 150, 3, 1'b0);

    repeat (32) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
